// ===== hdl/rational_arithmetic_unit_macros.svh =====
// Assertion macros for the rational arithmetic unit checker.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RAU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rational_arithmetic_unit: assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_arithmetic_unit: assertion failed");

`endif

// ===== hdl/rau_pkg.sv =====
// Types, widths, operation codes and helpers for the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int VAL_W         = 2 * OPERAND_WIDTH;
  localparam int SHIFT_W       = $clog2(VAL_W);
  localparam int CNT_W         = $clog2(VAL_W + 1);
  localparam int KIND_W        = 3;
  localparam int RES_NUM_W     = 33;
  localparam int RES_DEN_W     = 31;

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CMP = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  typedef struct packed {
    logic                     neg;
    logic [OPERAND_WIDTH-1:0] mag;
  } sm_op_t;

  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
  } sm_val_t;

  function automatic sm_op_t sm_from_field(logic [OPERAND_WIDTH-1:0] v);
    sm_op_t r;
    r.neg = v[OPERAND_WIDTH-1];
    r.mag = r.neg ? (~v + OPERAND_WIDTH'(1)) : v;
    return r;
  endfunction

  function automatic logic signed [VAL_W:0] sm_to_tc(sm_val_t x);
    logic signed [VAL_W:0] m;
    m = $signed({1'b0, x.mag});
    return x.neg ? -m : m;
  endfunction

endpackage

// ===== hdl/rau_op_if.sv =====
// Operand channel: operation code and two fractions.
interface rau_op_if import rau_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic [KIND_W-1:0]               kind;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== hdl/rau_res_if.sv =====
// Result channel: reduced fraction and compare flags.
interface rau_res_if import rau_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [RES_NUM_W-1:0] result_num;
  logic [RES_DEN_W-1:0]        result_den;
  logic                        is_less;
  logic                        is_greater;

  modport source (output valid, result_num, result_den, is_less, is_greater, input ready);
  modport sink   (input valid, result_num, result_den, is_less, is_greater, output ready);
endinterface

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: add, subtract, multiply, divide or compare two signed
// fractions, with results reduced to lowest terms and a positive denominator.
// One item is in work at a time; ready is low from acceptance until the result is
// handed to the output register, which may still hold the previous result while the
// next item is accepted. Every item first forms its cross products one at a time on
// the one shared 16x16 multiplier, then the raw fraction. Compare, unused codes and
// zero results then go straight to the output stage. Other arithmetic runs the binary
// GCD unit, one shift or subtract per cycle, and then two restoring divisions by the
// GCD on one shared divider, one for the numerator and one for the denominator.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  rau_op_if.sink    operands,
  rau_res_if.source results
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_FORM = 4'd2;
  localparam logic [3:0] S_GCD  = 4'd3;
  localparam logic [3:0] S_DIVN = 4'd4;
  localparam logic [3:0] S_DIVD = 4'd5;
  localparam logic [3:0] S_DONE = 4'd6;

  localparam logic [1:0] MSTEP_LAST = 2'd2;
  localparam int EXT_W = VAL_W + RES_NUM_W + 1;

  function automatic sm_op_t norm_num(sm_op_t n, sm_op_t d);
    sm_op_t r;
    r = '0;
    if (d.mag != '0) begin
      r.neg = n.neg ^ d.neg;
      r.mag = n.mag;
    end
    return r;
  endfunction

  function automatic sm_op_t norm_den(sm_op_t d);
    sm_op_t r;
    r.neg = 1'b0;
    r.mag = (d.mag == '0) ? OPERAND_WIDTH'(1) : d.mag;
    return r;
  endfunction

  logic [3:0]        state;
  logic [KIND_W-1:0] kind_r;
  sm_op_t            an, ad, bn, bd;
  sm_op_t            f_an, f_ad, f_bn, f_bd;
  logic [1:0]        mstep;
  sm_op_t            mx, my;
  sm_val_t           mp, p0, p1, p2;

  logic [VAL_W-1:0]  num_mag, den_mag, qn;
  logic              res_neg;
  logic              gcd_start, div_start;
  unit_status_t      gcd_st, div_st;
  logic [VAL_W-1:0]  gcd_g, div_q, div_dividend;

  logic signed [VAL_W:0]   t0, t1;
  logic signed [VAL_W+1:0] sum;
  logic [VAL_W+1:0]        sum_abs;
  logic [VAL_W-1:0]        f_num_mag;
  sm_val_t                 f_den;
  logic                    f_zero;

  logic signed [VAL_W:0]   qn_tc;
  logic [EXT_W-1:0]        num_ext, den_ext;

  logic [RES_NUM_W-1:0] pend_num, out_num;
  logic [RES_DEN_W-1:0] pend_den, out_den;
  logic                 pend_lt, pend_gt, out_lt, out_gt, res_valid;

  assign operands.ready = (state == S_IDLE);

  assign f_an = sm_from_field(operands.a_num);
  assign f_ad = sm_from_field(operands.a_den);
  assign f_bn = sm_from_field(operands.b_num);
  assign f_bd = sm_from_field(operands.b_den);

  // operand routing per multiply step
  always_comb begin
    case (mstep)
      2'd0: begin
        mx = an;
        my = (kind_r == KIND_MUL) ? bn : bd;
      end
      2'd1: begin
        mx = (kind_r == KIND_MUL) ? ad : bn;
        my = (kind_r == KIND_MUL) ? bd : ad;
      end
      default: begin
        mx = ad;
        my = bd;
      end
    endcase
  end

  rau_mul u_mul (.x(mx), .y(my), .p(mp));

  // raw fraction from the products
  always_comb begin
    t0 = sm_to_tc(p0);
    t1 = sm_to_tc(p1);
    case (kind_r)
      KIND_ADD: sum = (VAL_W+2)'(t0) + (VAL_W+2)'(t1);
      KIND_SUB: sum = (VAL_W+2)'(t0) - (VAL_W+2)'(t1);
      default:  sum = (VAL_W+2)'(t0);
    endcase
    sum_abs   = sum[VAL_W+1] ? (VAL_W+2)'(-sum) : (VAL_W+2)'(sum);
    f_num_mag = sum_abs[VAL_W-1:0];
    f_den     = (kind_r == KIND_ADD || kind_r == KIND_SUB) ? p2 : p1;
    f_zero    = (f_num_mag == '0) || (f_den.mag == '0);
  end

  assign div_dividend = (state == S_DIVD) ? den_mag : num_mag;

  rau_gcd u_gcd (
    .clk(clk), .rst(rst), .start(gcd_start),
    .m(num_mag), .n(den_mag), .status(gcd_st), .g(gcd_g)
  );

  rau_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_dividend), .divisor(gcd_g), .status(div_st), .quotient(div_q)
  );

  assign qn_tc   = res_neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
  assign num_ext = EXT_W'(qn_tc);
  assign den_ext = EXT_W'(div_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      gcd_start <= 1'b0;
      div_start <= 1'b0;
    end else begin
      gcd_start <= 1'b0;
      div_start <= 1'b0;
      if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (operands.valid) begin
            kind_r <= operands.kind;
            mstep  <= '0;
            state  <= S_MUL;
            if (operands.kind == KIND_CMP) begin
              an <= norm_num(f_an, f_ad);
              ad <= norm_den(f_ad);
              bn <= norm_num(f_bn, f_bd);
              bd <= norm_den(f_bd);
            end else begin
              an <= f_an;
              ad <= f_ad;
              bn <= f_bn;
              bd <= f_bd;
            end
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0:    p0 <= mp;
            2'd1:    p1 <= mp;
            default: p2 <= mp;
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == MSTEP_LAST) begin
            state <= S_FORM;
          end
        end
        S_FORM: begin
          pend_num <= '0;
          pend_den <= RES_DEN_W'(1);
          pend_lt  <= 1'b0;
          pend_gt  <= 1'b0;
          state    <= S_DONE;
          case (kind_r)
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
              if (!f_zero) begin
                num_mag   <= f_num_mag;
                den_mag   <= f_den.mag;
                res_neg   <= sum[VAL_W+1] ^ f_den.neg;
                gcd_start <= 1'b1;
                state     <= S_GCD;
              end
            end
            KIND_CMP: begin
              pend_lt <= t0 < t1;
              pend_gt <= t0 > t1;
            end
            default: begin
            end
          endcase
        end
        S_GCD: begin
          if (gcd_st.done) begin
            div_start <= 1'b1;
            state     <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_st.done) begin
            qn        <= div_q;
            div_start <= 1'b1;
            state     <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_st.done) begin
            pend_num <= num_ext[RES_NUM_W-1:0];
            pend_den <= den_ext[RES_DEN_W-1:0];
            pend_lt  <= 1'b0;
            pend_gt  <= 1'b0;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || results.ready) begin
            out_num   <= pend_num;
            out_den   <= pend_den;
            out_lt    <= pend_lt;
            out_gt    <= pend_gt;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid      = res_valid;
  assign results.result_num = $signed(out_num);
  assign results.result_den = out_den;
  assign results.is_less    = out_lt;
  assign results.is_greater = out_gt;

endmodule

// ===== hdl/rau_mul.sv =====
// Shared sign-magnitude multiplier for operand products.
module rau_mul import rau_pkg::*; (
  input  sm_op_t  x,
  input  sm_op_t  y,
  output sm_val_t p
);

  always_comb begin
    p.mag = VAL_W'(x.mag) * VAL_W'(y.mag);
    p.neg = (x.neg ^ y.neg) && (p.mag != '0);
  end

endmodule

// ===== hdl/rau_gcd.sv =====
// Binary GCD unit: one shift or subtract step per cycle.
module rau_gcd import rau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] m,
  input  logic [VAL_W-1:0] n,
  output unit_status_t     status,
  output logic [VAL_W-1:0] g
);

  logic               busy;
  logic               done;
  logic [VAL_W-1:0]   u;
  logic [VAL_W-1:0]   v;
  logic [SHIFT_W-1:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        u    <= m;
        v    <= n;
        k    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (u == '0 || v == '0) begin
          g    <= (u | v) << k;
          busy <= 1'b0;
          done <= 1'b1;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + SHIFT_W'(1);
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u >= v) begin
          u <= u - v;
        end else begin
          v <= v - u;
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// ===== hdl/rau_div.sv =====
// Restoring divider: one quotient bit per cycle.
module rau_div import rau_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output unit_status_t     status,
  output logic [VAL_W-1:0] quotient
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] quo;
  logic [VAL_W-1:0] dsr;
  logic [VAL_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[VAL_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= CNT_W'(VAL_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? VAL_W'(trial - {1'b0, dsr}) : VAL_W'(trial);
        quo <= {quo[VAL_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
  assign status   = '{busy: busy, done: done};

endmodule

// ===== hdl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, with its bind.
`include "rational_arithmetic_unit_macros.svh"

module rau_checker import rau_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 op_valid,
  input logic                 op_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [RES_NUM_W-1:0] result_num,
  input logic [RES_DEN_W-1:0] result_den,
  input logic                 is_less,
  input logic                 is_greater
);

  `RAU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  `RAU_ASSERT_NEXT(a_busy_after_accept, op_valid && op_ready, !op_ready)
  `RAU_ASSERT_SAME(a_den_nonzero, res_valid, result_den != '0)
  `RAU_ASSERT_SAME(a_cmp_shape, res_valid && (is_less || is_greater), !(is_less && is_greater) && (result_num == '0) && (result_den == RES_DEN_W'(1)))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk),
  .rst(rst),
  .op_valid(operands.valid),
  .op_ready(operands.ready),
  .res_valid(results.valid),
  .res_ready(results.ready),
  .result_num(results.result_num),
  .result_den(results.result_den),
  .is_less(results.is_less),
  .is_greater(results.is_greater)
);
